[sv/assert_macros.svh]
// Assertion macros shared by the canonical Huffman encoder RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/chenc_pkg.sv]
// Shared constants, types and helper functions for the canonical Huffman encoder.
// No dependencies; the interfaces, the code generator and the top level use this package.
package chenc_pkg;

  localparam int NUM_SYMBOLS = 512;
  localparam int MAX_LEN     = 16;

  localparam int OPC_W  = 2;
  localparam int SYM_W  = 9;
  localparam int LEN_W  = 5;
  localparam int CODE_W = 16;
  localparam int CNT_W  = 10;
  localparam int NC_W   = 17;

  localparam int ADDR_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int LIDX_W = $clog2(MAX_LEN + 1);

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_ENCODE = 2'd2
  } opcode_t;

  // Control from the sequencer to the code generator.
  typedef struct packed {
    logic             clear;
    logic             count_en;
    logic             calc_en;
    logic             assign_en;
    logic [LEN_W-1:0] len;
  } chenc_ctl_t;

  // Mask with the low len bits set.
  function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] m;
    for (int i = 0; i < CODE_W; i++) begin
      m[i] = (32'(len) > i);
    end
    return m;
  endfunction

endpackage

[sv/chenc_if.sv]
// Request channel interfaces of the canonical Huffman encoder.
// Depends on chenc_pkg for the field widths.
interface chenc_in_if;
  logic                          valid;
  logic                          ready;
  logic [chenc_pkg::OPC_W-1:0]   opcode;
  logic [chenc_pkg::SYM_W-1:0]   symbol;
  logic [chenc_pkg::LEN_W-1:0]   length;

  modport source (output valid, output opcode, output symbol, output length, input ready);
  modport sink   (input valid, input opcode, input symbol, input length, output ready);
endinterface

interface chenc_out_if;
  logic                          valid;
  logic                          ready;
  logic [chenc_pkg::CODE_W-1:0]  code;
  logic [chenc_pkg::LEN_W-1:0]   code_len;

  modport source (output valid, output code, output code_len, input ready);
  modport sink   (input valid, input code, input code_len, output ready);
endinterface

[sv/chenc_codegen.sv]
// Length counters, next-code registers and the one shared adder of the encoder.
// Depends on chenc_pkg; driven by the sequencer in the top level.
`include "assert_macros.svh"

module chenc_codegen (
  input  logic                          clk,
  input  logic                          rst_n,
  input  chenc_pkg::chenc_ctl_t         ctl,
  output logic [chenc_pkg::CODE_W-1:0]  asg_code
);

  logic [chenc_pkg::CNT_W-1:0]  counts_r [chenc_pkg::MAX_LEN+1];
  logic [chenc_pkg::NC_W-1:0]   next_r   [chenc_pkg::MAX_LEN+1];

  logic [chenc_pkg::LIDX_W-1:0] idx;
  logic [chenc_pkg::LIDX_W-1:0] rd_idx;
  logic [chenc_pkg::CNT_W-1:0]  cnt_rd;
  logic [chenc_pkg::NC_W-1:0]   nc_rd;
  logic [chenc_pkg::NC_W-1:0]   op_a;
  logic [chenc_pkg::NC_W-1:0]   op_b;
  logic [chenc_pkg::NC_W-1:0]   sum;

  assign idx    = chenc_pkg::LIDX_W'(ctl.len);
  // The first-code step reads the level below the one it writes.
  assign rd_idx = ctl.calc_en ? (idx - chenc_pkg::LIDX_W'(1)) : idx;
  assign cnt_rd = counts_r[rd_idx];
  assign nc_rd  = next_r[rd_idx];

  always_comb begin
    if (ctl.count_en) begin
      op_a = chenc_pkg::NC_W'(cnt_rd);
      op_b = chenc_pkg::NC_W'(1);
    end else if (ctl.calc_en) begin
      op_a = nc_rd;
      op_b = chenc_pkg::NC_W'(cnt_rd);
    end else begin
      op_a = nc_rd;
      op_b = chenc_pkg::NC_W'(1);
    end
  end

  assign sum      = op_a + op_b;
  assign asg_code = nc_rd[chenc_pkg::CODE_W-1:0] & chenc_pkg::len_mask(ctl.len);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      for (int i = 0; i <= chenc_pkg::MAX_LEN; i++) begin
        counts_r[i] <= '0;
        next_r[i]   <= '0;
      end
    end else if (ctl.count_en) begin
      counts_r[idx] <= sum[chenc_pkg::CNT_W-1:0];
    end else if (ctl.calc_en) begin
      next_r[idx] <= {sum[chenc_pkg::NC_W-2:0], 1'b0};
    end else if (ctl.assign_en) begin
      next_r[idx] <= sum;
    end
  end

  `CHK_IMPLY(a_one_op, 1'b1, $onehot0({ctl.count_en, ctl.calc_en, ctl.assign_en}), "adder shared by two operations")
  `CHK_IMPLY(a_calc_range, ctl.calc_en, (idx >= chenc_pkg::LIDX_W'(2)), "first code step below length two")

endmodule

[sv/canonical_huffman_encoder_unit.sv]
// Canonical Huffman encoder: length table, code table and build sequencer.
// Depends on chenc_pkg, chenc_if and chenc_codegen.
//
// After reset the block sweeps the length table to zero, one entry per cycle,
// over all NUM_SYMBOLS (512) entries, and takes no request meanwhile. A load
// request writes one code length in its accept cycle and the block is ready
// again in the next cycle. An encode request reads the length and code tables
// in its accept cycle into registers and then, in the encode state, places its
// result into the output register, waiting there while the output register
// stays full. A build request walks the length table twice through its single
// read port: one pass counts the lengths, a short pass of MAX_LEN-1 steps
// derives the first code of each length, and a second table pass hands out
// codes in ascending symbol order. All three passes run through one shared
// adder, and a build holds the block until the last pass has drained. Results
// wait in an output register, so the input side stays open while the consumer
// stalls, except during an encode whose result cannot yet be placed. Encoding
// a symbol before any build returns an undefined code.
`include "assert_macros.svh"

module canonical_huffman_encoder_unit (
  input  logic         clk,
  input  logic         rst_n,
  chenc_in_if.sink     in_ch,
  chenc_out_if.source  out_ch
);

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_COUNT  = 8'b0000_0100,
    S_CDRAIN = 8'b0000_1000,
    S_CALC   = 8'b0001_0000,
    S_ASSIGN = 8'b0010_0000,
    S_ADRAIN = 8'b0100_0000,
    S_ENC    = 8'b1000_0000
  } state_t;

  localparam logic [chenc_pkg::ADDR_W-1:0] LAST_ADDR =
    chenc_pkg::ADDR_W'(chenc_pkg::NUM_SYMBOLS - 1);

  state_t                          state_r, state_nxt;
  logic [chenc_pkg::ADDR_W-1:0]    ptr_r, ptr_nxt;
  logic [chenc_pkg::ADDR_W-1:0]    ptr_d_r;
  logic                            dvld_r;
  logic [chenc_pkg::LEN_W-1:0]     lvl_r, lvl_nxt;
  logic [chenc_pkg::ADDR_W-1:0]    sym_r;
  logic                            symok_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [chenc_pkg::CODE_W-1:0]    out_code_r;
  logic [chenc_pkg::LEN_W-1:0]     out_len_r;

  // Table storage. The length table is cleared by the sweep after reset;
  // the code table is only meaningful after a build.
  logic [chenc_pkg::LEN_W-1:0]     len_mem  [chenc_pkg::NUM_SYMBOLS];
  logic [chenc_pkg::CODE_W-1:0]    code_mem [chenc_pkg::NUM_SYMBOLS];
  logic [chenc_pkg::LEN_W-1:0]     len_q;
  logic [chenc_pkg::CODE_W-1:0]    code_q;

  logic                            acc;
  chenc_pkg::opcode_t              op;
  logic                            sym_ok;
  logic [chenc_pkg::ADDR_W-1:0]    sym_addr;
  logic [chenc_pkg::ADDR_W-1:0]    rd_addr;
  logic [chenc_pkg::ADDR_W-1:0]    wr_addr;
  logic [chenc_pkg::LEN_W-1:0]     wr_len;
  logic                            len_we;
  logic                            out_load;
  chenc_pkg::chenc_ctl_t           ctl;
  logic [chenc_pkg::CODE_W-1:0]    asg_code;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign op          = chenc_pkg::opcode_t'(in_ch.opcode);
  assign sym_ok      = (32'(in_ch.symbol) < chenc_pkg::NUM_SYMBOLS);
  assign sym_addr    = chenc_pkg::ADDR_W'(in_ch.symbol);

  // Table read address: the incoming symbol while idle, the held symbol while
  // an encode finishes, the sweep pointer during a build.
  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = sym_addr;
    end else if (state_r == S_ENC) begin
      rd_addr = sym_r;
    end else begin
      rd_addr = ptr_r;
    end
  end

  // Length table writes: the clearing sweep, or an in-range load.
  assign len_we  = (state_r == S_CLEAR) ||
                   (acc && (op == chenc_pkg::OP_LOAD) && sym_ok &&
                    (32'(in_ch.length) <= chenc_pkg::MAX_LEN));
  assign wr_addr = (state_r == S_CLEAR) ? ptr_r : sym_addr;
  assign wr_len  = (state_r == S_CLEAR) ? '0 : in_ch.length;

  // Build data arrives in the cycle after its address; the drain states catch
  // the last entry of each pass.
  always_comb begin
    ctl.clear     = acc && (op == chenc_pkg::OP_BUILD);
    ctl.count_en  = dvld_r && ((state_r == S_COUNT) || (state_r == S_CDRAIN));
    ctl.calc_en   = (state_r == S_CALC);
    ctl.assign_en = dvld_r && ((state_r == S_ASSIGN) || (state_r == S_ADRAIN));
    ctl.len       = ctl.calc_en ? lvl_r : len_q;
  end

  chenc_codegen u_codegen (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .asg_code (asg_code)
  );

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[wr_addr] <= wr_len;
    end
    if (ctl.assign_en) begin
      code_mem[ptr_d_r] <= asg_code;
    end
    len_q  <= len_mem[rd_addr];
    code_q <= code_mem[rd_addr];
  end

  // An encode result is placed once the output register is free; a symbol
  // out of range or of length zero finishes without a result.
  assign out_load = (state_r == S_ENC) && symok_r && (len_q != '0) &&
                    (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    lvl_nxt   = lvl_r;
    unique case (state_r)
      S_CLEAR: begin
        ptr_nxt = ptr_r + chenc_pkg::ADDR_W'(1);
        if (ptr_r == LAST_ADDR) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          unique case (op)
            chenc_pkg::OP_BUILD:  state_nxt = S_COUNT;
            chenc_pkg::OP_ENCODE: state_nxt = S_ENC;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_COUNT: begin
        ptr_nxt = ptr_r + chenc_pkg::ADDR_W'(1);
        if (ptr_r == LAST_ADDR) begin
          ptr_nxt   = '0;
          state_nxt = S_CDRAIN;
        end
      end
      S_CDRAIN: begin
        lvl_nxt   = chenc_pkg::LEN_W'(2);
        state_nxt = S_CALC;
      end
      S_CALC: begin
        lvl_nxt = lvl_r + chenc_pkg::LEN_W'(1);
        if (lvl_r == chenc_pkg::LEN_W'(chenc_pkg::MAX_LEN)) begin
          state_nxt = S_ASSIGN;
        end
      end
      S_ASSIGN: begin
        ptr_nxt = ptr_r + chenc_pkg::ADDR_W'(1);
        if (ptr_r == LAST_ADDR) begin
          ptr_nxt   = '0;
          state_nxt = S_ADRAIN;
        end
      end
      S_ADRAIN: begin
        state_nxt = S_IDLE;
      end
      S_ENC: begin
        if (!symok_r || (len_q == '0) || out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      dvld_r      <= 1'b0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      dvld_r      <= (state_r == S_COUNT) || (state_r == S_ASSIGN);
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_d_r <= ptr_r;
    if (acc) begin
      sym_r   <= sym_addr;
      symok_r <= sym_ok;
    end
    if (out_load) begin
      out_code_r <= code_q & chenc_pkg::len_mask(len_q);
      out_len_r  <= len_q;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.code     = out_code_r;
  assign out_ch.code_len = out_len_r;

  `CHK_IMPLY(a_drain_has_data, (state_r == S_CDRAIN) || (state_r == S_ADRAIN),
             dvld_r, "table pass drained without its last entry")
  `CHK_IMPLY(a_calc_no_data, state_r == S_CALC, !dvld_r,
             "table data pending during first code step")
  `CHK_NEXT(a_count_to_drain, (state_r == S_COUNT) && (ptr_r == LAST_ADDR),
            state_r == S_CDRAIN, "count pass did not end after the last entry")
  `CHK_IMPLY(a_result_from_encode, $rose(out_valid_r), $past(state_r) == S_ENC,
             "result appeared outside an encode")

endmodule
